/* rtl/cle_pkg.sv */
package cle_pkg;

  // Keystroke codes with an editing meaning; every other byte is inserted.
  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_BACK  = 8'h2D;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEFT_WR,
    ST_RIGHT_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMPTY
  } state_t;

  // One result item as it travels to the output register.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       overflowed;
    logic       last_of_line;
  } result_t;

endpackage

/* rtl/cursor_line_editor.sv */
// Line editor driven by keystroke bytes, kept as a gap buffer in one
// synchronous memory of CAPACITY characters.
// Input channel: key and end_of_line, transferred when in_valid is high and
// in_stall is low. '<' and '>' move the cursor, '-' deletes left of it, any
// other byte is inserted at the cursor (dropped, setting the sticky overflow
// flag, when the line is full).
// Insert, backspace and a cursor move that hits an end need no memory read.
// Any other cursor move passes through ST_LEFT_WR or ST_RIGHT_WR, since one
// character is read from the memory and written back across the gap, and
// the memory has one read and one write port with a registered read.
// With end_of_line set, the key is applied and the line is then sent out,
// one result per character, each read from the memory and then loaded into
// the output register. An empty line gives a single result with char_valid low.
// in_stall is high from the transfer of a key until its work is done.
// When the receiver stalls, the output register holds its result and the
// emission waits. Reset clears the line, the cursor and the overflow flag;
// the memory needs no clearing since only written entries are ever read.
module cursor_line_editor #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] key,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       overflowed,
  output logic       last_of_line
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_W = CW'(1);

  cle_pkg::state_t state, state_next;
  logic [CW-1:0] len, len_next;
  logic [CW-1:0] cursor, cursor_next;
  logic [CW-1:0] idx, idx_next;
  logic          ovf, ovf_next;
  logic          eol_pend, eol_pend_next;

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_data;
  logic          mem_we, mem_re;
  logic [IW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  logic             out_load, out_free;
  cle_pkg::result_t out_item;

  logic          accept;
  logic [CW-1:0] gap_end;
  logic [CW-1:0] emit_addr;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != cle_pkg::ST_IDLE);

  // First memory slot of the text right of the cursor.
  assign gap_end = CAP_W - len + cursor;
  // Emission index mapped around the gap.
  assign emit_addr = (idx < cursor) ? idx : (idx + CAP_W - len);

  // Next state, pointer updates and memory accesses.
  always_comb begin
    state_next    = state;
    len_next      = len;
    cursor_next   = cursor;
    idx_next      = idx;
    ovf_next      = ovf;
    eol_pend_next = eol_pend;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = cursor[IW-1:0];
    raddr         = cursor[IW-1:0];
    wdata         = key;
    out_load      = 1'b0;
    out_item      = '0;
    case (state)
      cle_pkg::ST_IDLE: begin
        if (accept) begin
          eol_pend_next = end_of_line;
          case (key)
            cle_pkg::KEY_LEFT: begin
              if (cursor != '0) begin
                mem_re     = 1'b1;
                raddr      = IW'(cursor - ONE_W);
                state_next = cle_pkg::ST_LEFT_WR;
              end
            end
            cle_pkg::KEY_RIGHT: begin
              if (cursor != len) begin
                mem_re     = 1'b1;
                raddr      = gap_end[IW-1:0];
                state_next = cle_pkg::ST_RIGHT_WR;
              end
            end
            cle_pkg::KEY_BACK: begin
              if (cursor != '0) begin
                cursor_next = cursor - ONE_W;
                len_next    = len - ONE_W;
              end
            end
            default: begin
              if (len == CAP_W) begin
                ovf_next = 1'b1;
              end else begin
                mem_we      = 1'b1;
                waddr       = cursor[IW-1:0];
                wdata       = key;
                cursor_next = cursor + ONE_W;
                len_next    = len + ONE_W;
              end
            end
          endcase
          // Keys that need no memory move go straight on to emission.
          if (state_next == cle_pkg::ST_IDLE && end_of_line) begin
            idx_next   = '0;
            state_next = (len_next == '0) ? cle_pkg::ST_EMPTY : cle_pkg::ST_EMIT_RD;
          end
        end
      end
      cle_pkg::ST_LEFT_WR: begin
        // Character left of the cursor moves to just below the gap end.
        mem_we      = 1'b1;
        waddr       = IW'(gap_end - ONE_W);
        wdata       = rd_data;
        cursor_next = cursor - ONE_W;
        idx_next    = '0;
        state_next  = eol_pend ? cle_pkg::ST_EMIT_RD : cle_pkg::ST_IDLE;
      end
      cle_pkg::ST_RIGHT_WR: begin
        // Character at the gap end moves to the cursor slot.
        mem_we      = 1'b1;
        waddr       = cursor[IW-1:0];
        wdata       = rd_data;
        cursor_next = cursor + ONE_W;
        idx_next    = '0;
        state_next  = eol_pend ? cle_pkg::ST_EMIT_RD : cle_pkg::ST_IDLE;
      end
      cle_pkg::ST_EMIT_RD: begin
        mem_re     = 1'b1;
        raddr      = emit_addr[IW-1:0];
        state_next = cle_pkg::ST_EMIT_WAIT;
      end
      cle_pkg::ST_EMIT_WAIT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_item.out_char     = rd_data;
          out_item.char_valid   = 1'b1;
          out_item.overflowed   = ovf;
          out_item.last_of_line = (idx + ONE_W == len);
          if (idx + ONE_W == len) begin
            len_next    = '0;
            cursor_next = '0;
            state_next  = cle_pkg::ST_IDLE;
          end else begin
            idx_next   = idx + ONE_W;
            state_next = cle_pkg::ST_EMIT_RD;
          end
        end
      end
      cle_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_item.out_char     = '0;
          out_item.char_valid   = 1'b0;
          out_item.overflowed   = ovf;
          out_item.last_of_line = 1'b1;
          state_next            = cle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cle_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cle_pkg::ST_IDLE;
      len      <= '0;
      cursor   <= '0;
      idx      <= '0;
      ovf      <= 1'b0;
      eol_pend <= 1'b0;
    end else begin
      state    <= state_next;
      len      <= len_next;
      cursor   <= cursor_next;
      idx      <= idx_next;
      ovf      <= ovf_next;
      eol_pend <= eol_pend_next;
    end
  end

  // Line memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  cle_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (out_load),
    .load_item    (out_item),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .char_valid   (char_valid),
    .overflowed   (overflowed),
    .last_of_line (last_of_line)
  );

  // The cursor never passes the end of the line, and the line fits the memory.
  assert property (@(posedge clk) disable iff (rst) (cursor <= len) && (len <= CAP_W))
    else $error("cursor or line length out of range");

  // The overflow flag is sticky.
  assert property (@(posedge clk) disable iff (rst) ovf |=> ovf)
    else $error("overflow flag cleared without reset");

  // No memory write while the line is being sent out.
  assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::ST_EMIT_RD || state == cle_pkg::ST_EMIT_WAIT) |-> !mem_we)
    else $error("memory written during emission");

  // A result is loaded only into a free output register.
  assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("result loaded over a stalled result");

endmodule

/* rtl/cle_out_reg.sv */
module cle_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cle_pkg::result_t load_item,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             overflowed,
  output logic             last_of_line
);

  cle_pkg::result_t item;

  // The register can take a new result when empty or when its transfer completes now.
  assign free = !out_valid || !out_stall;

  // Valid flag: set on load, cleared once the held result has been transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

  assign out_char     = item.out_char;
  assign char_valid   = item.char_valid;
  assign overflowed   = item.overflowed;
  assign last_of_line = item.last_of_line;

endmodule

/* bench/cursor_line_editor_test.sv */
`timescale 1ns / 100ps

module cursor_line_editor_test;

  localparam int CAPACITY = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] key;
  logic       end_of_line;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       char_valid;
  logic       overflowed;
  logic       last_of_line;

  // Shadow copy of the line being edited.
  logic [7:0] line_chars [CAPACITY];
  int unsigned line_len;
  int unsigned cursor;
  logic overflow_seen;
  cle_pkg::result_t pending_chars [$];

  int send_idle_pct;
  int recv_idle_pct;
  int errors = 0;
  int cycles = 0;

  cursor_line_editor #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .key(key),
    .end_of_line(end_of_line),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .char_valid(char_valid),
    .overflowed(overflowed),
    .last_of_line(last_of_line)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one keystroke to the shadow line and queue the characters it emits.
  task automatic edit_line(input logic [7:0] k, input logic eol);
    cle_pkg::result_t r;
    case (k)
      cle_pkg::KEY_LEFT: begin
        if (cursor > 0) cursor--;
      end
      cle_pkg::KEY_RIGHT: begin
        if (cursor < line_len) cursor++;
      end
      cle_pkg::KEY_BACK: begin
        if (cursor > 0) begin
          for (int unsigned i = cursor; i < line_len; i++) line_chars[i - 1] = line_chars[i];
          line_len--;
          cursor--;
        end
      end
      default: begin
        if (line_len >= CAPACITY) begin
          overflow_seen = 1'b1;
        end else begin
          for (int unsigned i = line_len; i > cursor; i--) line_chars[i] = line_chars[i - 1];
          line_chars[cursor] = k;
          line_len++;
          cursor++;
        end
      end
    endcase
    if (eol) begin
      if (line_len == 0) begin
        r.out_char = 8'h00;
        r.char_valid = 1'b0;
        r.overflowed = overflow_seen;
        r.last_of_line = 1'b1;
        pending_chars.push_back(r);
      end else begin
        for (int unsigned i = 0; i < line_len; i++) begin
          r.out_char = line_chars[i];
          r.char_valid = 1'b1;
          r.overflowed = overflow_seen;
          r.last_of_line = (i + 1 == line_len);
          pending_chars.push_back(r);
        end
      end
      line_len = 0;
      cursor = 0;
    end
  endtask

  // Offer one keystroke, possibly after a random gap, and wait for its transfer.
  task automatic send_key(input logic [7:0] k, input logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      key <= 8'($urandom);
      end_of_line <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key <= k;
    end_of_line <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    edit_line(k, eol);
  endtask

  function automatic logic [7:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return cle_pkg::KEY_LEFT;
    if (roll < 32) return cle_pkg::KEY_RIGHT;
    if (roll < 44) return cle_pkg::KEY_BACK;
    return 8'($urandom);
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Cursor moves and backspace on an empty line, then two empty lines emitted.
  task automatic test_cursor_ends();
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b1);
    send_key(cle_pkg::KEY_RIGHT, 1'b1);
  endtask

  // Inserts at both ends and the middle, deletes, and moves that hit the ends.
  task automatic test_edits();
    send_key(8'h00, 1'b0);
    send_key(8'hFF, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(8'h41, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b0);
    send_key(8'h7F, 1'b1);
    send_key(8'hFF, 1'b1);
  endtask

  // Random lines of a few keystrokes each, the last one closing the line.
  task automatic test_random_lines(input int n_keys);
    int sent;
    int len;
    sent = 0;
    while (sent < n_keys) begin
      len = $urandom_range(1, 14);
      for (int j = 0; j < len; j++) send_key(pick_key(), j == len - 1);
      sent += len;
    end
  endtask

  // Fill the line, insert into it while full, then check the flag stays set.
  task automatic test_full_line();
    for (int j = 0; j < CAPACITY; j++) send_key(8'($urandom_range(8'h40, 8'h7E)), 1'b0);
    send_key(8'h5A, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(cle_pkg::KEY_LEFT, 1'b0);
    send_key(8'h21, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b0);
    send_key(8'h22, 1'b0);
    send_key(8'h23, 1'b0);
    send_key(cle_pkg::KEY_RIGHT, 1'b1);
    send_key(8'h31, 1'b0);
    send_key(cle_pkg::KEY_BACK, 1'b1);
    send_key(8'h32, 1'b1);
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Compare each transferred result with the oldest expected character.
  always @(posedge clk) begin
    cle_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected result char=%h valid=%b ovf=%b last=%b", $time,
                 out_char, char_valid, overflowed, last_of_line);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.out_char) begin
          $display("%0t: out_char expected %h actual %h", $time, want.out_char, out_char);
          errors++;
        end
        if (char_valid !== want.char_valid) begin
          $display("%0t: char_valid expected %b actual %b", $time, want.char_valid,
                   char_valid);
          errors++;
        end
        if (overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %b actual %b", $time, want.overflowed,
                   overflowed);
          errors++;
        end
        if (last_of_line !== want.last_of_line) begin
          $display("%0t: last_of_line expected %b actual %b", $time, want.last_of_line,
                   last_of_line);
          errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    line_len = 0;
    cursor = 0;
    overflow_seen = 1'b0;
    set_idling(21, 81);
    rst <= 1'b1;
    in_valid <= 1'b0;
    key <= 8'h00;
    end_of_line <= 1'b0;
    out_stall <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cursor_ends();
    test_edits();
    test_random_lines(35);
    set_idling(81, 21);
    test_random_lines(35);
    set_idling(0, 0);
    test_random_lines(35);
    test_full_line();
    in_valid <= 1'b0;

    // Let the last line drain, then allow a few cycles for stray results.
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* cursor_line_editor.f */
rtl/cle_pkg.sv
rtl/cle_out_reg.sv
rtl/cursor_line_editor.sv
bench/cursor_line_editor_test.sv
